[design/lifo_stack_with_search_reverse_assert.svh]
// Assertion macros for the LIFO stack block
`ifndef LIFO_STACK_WITH_SEARCH_REVERSE_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_REVERSE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset
`define LSWSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset
`define LSWSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lswsr_pkg.sv]
// Shared types and constants for the LIFO stack block
package lswsr_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_SEARCH  = 2'd2;
  localparam logic [1:0] KIND_REVERSE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data_value;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] popped_value;
    logic        found;
    logic [31:0] top_value;
    logic [31:0] bottom_value;
    logic [4:0]  entry_count;
    logic        is_empty;
  } out_t;

endpackage

[design/lswsr_mem.sv]
// Entry store: one write port, one read port with registered read data
module lswsr_mem #(
  parameter int DEPTH = lswsr_pkg::DEF_STACK_DEPTH,
  parameter int WIDTH = lswsr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/lswsr_core.sv]
// Sequencer and datapath: walks the entry store through one read port
module lswsr_core #(
  parameter int STACK_DEPTH = lswsr_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = lswsr_pkg::DEF_VALUE_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lswsr_pkg::in_t  req,
  output logic            idle,
  output logic            done,
  input  logic            take,
  output lswsr_pkg::out_t result
);
  import lswsr_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PUSH    = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_POP_WT  = 4'd3;
  localparam logic [3:0] S_SRCH    = 4'd4;
  localparam logic [3:0] S_REV_RDI = 4'd5;
  localparam logic [3:0] S_REV_RDJ = 4'd6;
  localparam logic [3:0] S_REV_WRI = 4'd7;
  localparam logic [3:0] S_REV_WRJ = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]             state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic                   pend;
  logic                   ok;
  logic                   found;
  logic [VALUE_WIDTH-1:0] word;
  logic [VALUE_WIDTH-1:0] popped;
  logic [VALUE_WIDTH-1:0] top;
  logic [VALUE_WIDTH-1:0] bottom;
  logic [VALUE_WIDTH-1:0] tmp;

  logic [CW-1:0]          jdx;
  logic [CW-1:0]          half;
  logic [CW-1:0]          raddr_full;
  logic [CW-1:0]          waddr_full;
  logic                   we;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   srch_issue;
  logic                   hit;
  logic [63:0]            req64;
  logic [63:0]            pop64;
  logic [63:0]            top64;
  logic [63:0]            bot64;
  logic [63:0]            cnt64;
  logic                   has_entry;

  assign jdx        = count - ONE_C - idx;
  assign half       = count >> 1;
  assign srch_issue = (idx < count) && !found;
  // shared compare unit: one stored entry against the search word per cycle
  assign hit        = pend && (rdata == word);
  assign req64      = 64'(req.data_value);

  always_comb begin
    case (state)
      S_POP:     raddr_full = count - TWO_C;
      S_REV_RDJ: raddr_full = jdx;
      default:   raddr_full = idx;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr_full = count;
    wdata      = word;
    case (state)
      S_PUSH: begin
        we = (count < DEPTH_C);
      end
      S_REV_WRI: begin
        we         = 1'b1;
        waddr_full = idx;
        wdata      = rdata;
      end
      S_REV_WRJ: begin
        we         = 1'b1;
        waddr_full = jdx;
        wdata      = tmp;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  lswsr_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            word   <= req64[VALUE_WIDTH-1:0];
            ok     <= 1'b1;
            popped <= '0;
            found  <= 1'b0;
            idx    <= '0;
            pend   <= 1'b0;
            case (req.kind)
              KIND_PUSH:   state <= S_PUSH;
              KIND_POP:    state <= S_POP;
              KIND_SEARCH: state <= S_SRCH;
              default:     state <= S_REV_RDI;
            endcase
          end
        end
        S_PUSH: begin
          if (count < DEPTH_C) begin
            top <= word;
            if (count == '0) begin
              bottom <= word;
            end
            count <= count + ONE_C;
          end else begin
            ok <= 1'b0;
          end
          state <= S_DONE;
        end
        S_POP: begin
          if (count == '0) begin
            ok    <= 1'b0;
            state <= S_DONE;
          end else begin
            popped <= top;
            count  <= count - ONE_C;
            // fetch the entry below the old top as the new top
            state  <= (count >= TWO_C) ? S_POP_WT : S_DONE;
          end
        end
        S_POP_WT: begin
          top   <= rdata;
          state <= S_DONE;
        end
        S_SRCH: begin
          if (hit) begin
            found <= 1'b1;
          end
          if (srch_issue) begin
            idx <= idx + ONE_C;
          end
          pend <= srch_issue;
          if (!srch_issue && !pend) begin
            state <= S_DONE;
          end
        end
        S_REV_RDI: begin
          if (idx >= half) begin
            top    <= bottom;
            bottom <= top;
            state  <= S_DONE;
          end else begin
            state <= S_REV_RDJ;
          end
        end
        S_REV_RDJ: begin
          tmp   <= rdata;
          state <= S_REV_WRI;
        end
        S_REV_WRI: begin
          state <= S_REV_WRJ;
        end
        S_REV_WRJ: begin
          idx   <= idx + ONE_C;
          state <= S_REV_RDI;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign done      = (state == S_DONE);
  assign has_entry = (count != '0);
  assign pop64     = 64'(popped);
  assign top64     = 64'(top);
  assign bot64     = 64'(bottom);
  assign cnt64     = 64'(count);

  always_comb begin
    result.ok           = ok;
    result.popped_value = pop64[31:0];
    result.found        = found;
    result.top_value    = has_entry ? top64[31:0] : 32'd0;
    result.bottom_value = has_entry ? bot64[31:0] : 32'd0;
    result.entry_count  = cnt64[4:0];
    result.is_empty     = !has_entry;
  end

endmodule

[design/lifo_stack_with_search_reverse.sv]
// One request at a time; the search walk and the reverse swaps run through the
// single read port of the entry store. A new request is taken while the previous
// result waits in the output register, from the cycle after the handover.
// Synchronous active-high reset empties the stack; entry contents are not cleared.
module lifo_stack_with_search_reverse #(
  parameter int STACK_DEPTH = lswsr_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = lswsr_pkg::DEF_VALUE_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lswsr_pkg::in_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output lswsr_pkg::out_t rsp_data
);
  import lswsr_pkg::*;

  `include "lifo_stack_with_search_reverse_assert.svh"

  logic idle;
  logic done;
  logic take;
  out_t result;

  // hand the result over once the output register is free or being drained
  assign take      = done && (!rsp_valid || rsp_ready);
  assign req_ready = idle;

  lswsr_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (req_valid && idle),
    .req    (req_data),
    .idle   (idle),
    .done   (done),
    .take   (take),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= result;
    end
  end

  `LSWSR_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
                     "request accepted but block still ready")
  `LSWSR_ASSERT_NOW(a_fail_no_pop, rsp_valid && !rsp_data.ok,
                    rsp_data.popped_value == 32'd0, "refused request carries a value")
  `LSWSR_ASSERT_NOW(a_found_ok, rsp_valid && rsp_data.found, rsp_data.ok,
                    "search hit without ok")
  `LSWSR_ASSERT_NOW(a_empty_count, rsp_valid,
                    rsp_data.is_empty == (rsp_data.entry_count == 5'd0),
                    "empty flag disagrees with count")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LIFO stack with search and reverse
module tb;
  import lswsr_pkg::*;

  localparam int DEPTH        = DEF_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  // longest request is a reverse of a full stack
  localparam int DRAIN_CYCLES = 4 * (DEPTH / 2) + 8;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } step_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp_data;

  logic [31:0] shadow_mem [DEPTH];
  int          shadow_count = 0;
  out_t        pending_results [$];
  step_row_t   script [$];
  bit          calm = 1'b0;

  int errors      = 0;
  int cycles      = 0;
  int checked     = 0;
  int n_refused   = 0;
  int n_empty_pop = 0;
  int n_hits      = 0;
  int n_misses    = 0;
  int n_reverse   = 0;

  always #4 clk = ~clk;

  lifo_stack_with_search_reverse u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // Advance the shadow stack by one request and return the result it should give
  function automatic out_t apply_stack_op(in_t req);
    out_t        r;
    logic [31:0] t;
    int          i;
    r = '0;
    case (req.kind)
      KIND_PUSH: begin
        if (shadow_count < DEPTH) begin
          shadow_mem[shadow_count] = req.data_value;
          shadow_count++;
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      KIND_POP: begin
        if (shadow_count > 0) begin
          shadow_count--;
          r.popped_value = shadow_mem[shadow_count];
          r.ok = 1'b1;
        end else begin
          n_empty_pop++;
        end
      end
      KIND_SEARCH: begin
        r.ok = 1'b1;
        for (i = 0; i < shadow_count; i++)
          if (shadow_mem[i] == req.data_value) r.found = 1'b1;
        if (r.found) n_hits++;
        else n_misses++;
      end
      KIND_REVERSE: begin
        r.ok = 1'b1;
        for (i = 0; i < shadow_count / 2; i++) begin
          t = shadow_mem[i];
          shadow_mem[i] = shadow_mem[shadow_count - 1 - i];
          shadow_mem[shadow_count - 1 - i] = t;
        end
        n_reverse++;
      end
    endcase
    if (shadow_count > 0) begin
      r.top_value    = shadow_mem[shadow_count - 1];
      r.bottom_value = shadow_mem[0];
    end
    r.entry_count = shadow_count[4:0];
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  function automatic out_t stack_view(logic ok, logic [31:0] popped, logic found,
                                      logic [31:0] top, logic [31:0] bottom,
                                      logic [4:0] count);
    out_t v;
    v.ok           = ok;
    v.popped_value = popped;
    v.found        = found;
    v.top_value    = top;
    v.bottom_value = bottom;
    v.entry_count  = count;
    v.is_empty     = (count == 0);
    return v;
  endfunction

  task automatic add_step(logic [1:0] kind, logic [31:0] value, bit typed, out_t want);
    step_row_t row;
    row.req.kind       = kind;
    row.req.data_value = value;
    row.typed          = typed;
    row.want           = want;
    script.push_back(row);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk)
    rsp_ready <= !rst && (calm || $urandom_range(99) >= 9);

  always @(posedge clk) begin
    out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", rsp_data.top_value, '0);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (rsp_data.ok !== want.ok)
          report_mismatch("ok", rsp_data.ok, want.ok);
        if (rsp_data.popped_value !== want.popped_value)
          report_mismatch("popped_value", rsp_data.popped_value, want.popped_value);
        if (rsp_data.found !== want.found)
          report_mismatch("found", rsp_data.found, want.found);
        if (rsp_data.top_value !== want.top_value)
          report_mismatch("top_value", rsp_data.top_value, want.top_value);
        if (rsp_data.bottom_value !== want.bottom_value)
          report_mismatch("bottom_value", rsp_data.bottom_value, want.bottom_value);
        if (rsp_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
        if (rsp_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", rsp_data.is_empty, want.is_empty);
      end
    end
  end

  initial begin
    in_t  item;
    out_t predicted;
    int   n;
    int   k;
    int   total;
    int   mode;
    int   push_pct;
    int   pop_pct;
    int   r;

    // empty-stack cases, a single entry, then fill to the brim
    add_step(KIND_POP,     32'hDEAD_BEEF, 1, stack_view(0, 0, 0, 0, 0, 0));
    add_step(KIND_SEARCH,  32'hFFFF_FFFF, 1, stack_view(1, 0, 0, 0, 0, 0));
    add_step(KIND_REVERSE, 32'h0000_0000, 1, stack_view(1, 0, 0, 0, 0, 0));
    add_step(KIND_PUSH,    32'hFFFF_FFFF, 1,
             stack_view(1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_step(KIND_REVERSE, 32'h5555_5555, 1,
             stack_view(1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_step(KIND_SEARCH,  32'hFFFF_FFFF, 1,
             stack_view(1, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_step(KIND_POP,     32'hAAAA_AAAA, 1, stack_view(1, 32'hFFFF_FFFF, 0, 0, 0, 0));
    for (k = 0; k < DEPTH; k++)
      add_step(KIND_PUSH, k * 32'h1111_1111, 0, '0);
    add_step(KIND_PUSH,    32'h8000_0000, 1,
             stack_view(0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd16));
    add_step(KIND_SEARCH,  32'h0000_0000, 0, '0);
    add_step(KIND_SEARCH,  32'h1234_5678, 0, '0);
    add_step(KIND_REVERSE, 32'h0F0F_0F0F, 0, '0);
    add_step(KIND_POP,     32'h0000_0000, 0, '0);

    total    = script.size() + RANDOM_ITEMS;
    mode     = 2;
    push_pct = 35;
    pop_pct  = 30;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < total; n++) begin
      calm <= (n >= 600 && n < 900);
      if (n < script.size()) begin
        item = script[n].req;
      end else begin
        // swing between filling, draining and a mix so both ends get hit
        if ((n - script.size()) % 32 == 0) begin
          mode = $urandom_range(2);
          case (mode)
            0:       begin push_pct = 60; pop_pct = 15; end
            1:       begin push_pct = 15; pop_pct = 60; end
            default: begin push_pct = 35; pop_pct = 30; end
          endcase
        end
        r = $urandom_range(99);
        if (r < push_pct)                item.kind = KIND_PUSH;
        else if (r < push_pct + pop_pct) item.kind = KIND_POP;
        else if (r < 85)                 item.kind = KIND_SEARCH;
        else                             item.kind = KIND_REVERSE;
        r = $urandom_range(99);
        if (item.kind == KIND_SEARCH && shadow_count > 0 && $urandom_range(1) == 1)
          item.data_value = shadow_mem[$urandom_range(shadow_count - 1)];
        else if (r < 6)  item.data_value = '0;
        else if (r < 12) item.data_value = '1;
        else if (r < 30) item.data_value = $urandom_range(15);
        else             item.data_value = $urandom;
      end

      if (n < 600 || n >= 900)
        while ($urandom_range(99) < 9) begin
          req_valid <= 1'b0;
          @(posedge clk);
        end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clk); while (!req_ready);

      predicted = apply_stack_op(item);
      if (n < script.size() && script[n].typed)
        pending_results.push_back(script[n].want);
      else
        pending_results.push_back(predicted);
    end
    req_valid <= 1'b0;
    calm      <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d requests; %0d pushes refused when full, %0d pops on empty",
             checked, total, n_refused, n_empty_pop);
    $display("Searches: %0d hits, %0d misses; %0d reversals", n_hits, n_misses, n_reverse);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/lswsr_pkg.sv
design/lswsr_mem.sv
design/lswsr_core.sv
design/lifo_stack_with_search_reverse.sv
verif/tb.sv
